### rtl/cbls_pkg.sv
// Shared types, constants and constant tables of the copper bar line shader.
package cbls_pkg;

   localparam int TABLE_BARS = 6;
   localparam int REF_LINES  = 240;
   localparam int MAX_LINES  = 1024;
   localparam int ROWS_W     = 11;
   localparam int CENTRE_W   = 22;
   localparam int DIV_BITS   = 9;
   localparam int GAUSS_LAST = 26;

   // 2*REF_LINES = 15 << HALF_SHIFT; x/15 as (x*HALF_RECIP) >> 24, exact for x < 2^20
   localparam int HALF_SHIFT = 5;
   localparam logic [20:0] HALF_RECIP = 21'd1118482;

   localparam logic KIND_FRAME = 1'b0;
   localparam logic KIND_LINE  = 1'b1;

   localparam logic CSR_PALETTE = 1'b0;
   localparam logic CSR_LINES   = 1'b1;

   typedef enum logic [4:0] {
      OP_NOP, OP_LOAD, OP_ANGLE, OP_SINU, OP_Q1, OP_Q2, OP_Q3, OP_Q4,
      OP_POS, OP_ROW, OP_HALF1, OP_HALF2, OP_DIFF, OP_DIVINIT, OP_DIV,
      OP_LUMU, OP_BODY, OP_GAUSS, OP_LUM, OP_RGB, OP_EMIT
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [3:0] div_step;
   } cmd_type;

   typedef struct packed {
      logic line_ok;
      logic covered;
   } status_type;

   function automatic logic [15:0] bar_centre_q16(input logic [2:0] b);
      logic [15:0] v;
      case (b)
         3'd0: v = 16'd10486;
         3'd1: v = 16'd20316;
         3'd2: v = 16'd29491;
         3'd3: v = 16'd38011;
         3'd4: v = 16'd47186;
         3'd5: v = 16'd56361;
         default: v = 16'd0;
      endcase
      return v;
   endfunction

   function automatic logic [13:0] bar_amp_q16(input logic [2:0] b);
      logic [13:0] v;
      case (b)
         3'd0: v = 14'd8520;
         3'd1: v = 14'd10486;
         3'd2: v = 14'd9175;
         3'd3: v = 14'd11141;
         3'd4: v = 14'd9830;
         3'd5: v = 14'd7864;
         default: v = 14'd0;
      endcase
      return v;
   endfunction

   function automatic logic [31:0] bar_speed(input logic [2:0] b);
      logic [31:0] v;
      case (b)
         3'd0: v = 32'd567359179;
         3'd1: v = 32'd868127900;
         3'd2: v = 32'd416974818;
         3'd3: v = 32'd1045854872;
         3'd4: v = 32'd663058317;
         3'd5: v = 32'd1223581843;
         default: v = 32'd0;
      endcase
      return v;
   endfunction

   function automatic logic [31:0] bar_phase(input logic [2:0] b);
      logic [31:0] v;
      case (b)
         3'd0: v = 32'd0;
         3'd1: v = 32'd1298774024;
         3'd2: v = 32'd2324121937;
         3'd3: v = 32'd478495693;
         3'd4: v = 32'd3281113323;
         3'd5: v = 32'd1777269717;
         default: v = 32'd0;
      endcase
      return v;
   endfunction

   function automatic logic [4:0] bar_height(input logic [2:0] b);
      logic [4:0] v;
      case (b)
         3'd0: v = 5'd22;
         3'd1: v = 5'd18;
         3'd2: v = 5'd26;
         3'd3: v = 5'd16;
         3'd4: v = 5'd24;
         3'd5: v = 5'd20;
         default: v = 5'd0;
      endcase
      return v;
   endfunction

   // chan 0..2 bar colour r, g, b; 3..5 background r, g, b
   function automatic logic [7:0] pal_value(input logic [2:0] sel, input logic [2:0] chan);
      logic [2:0] p;
      logic [7:0] v;
      p = (sel >= 3'd5) ? 3'(sel - 3'd5) : sel;
      case ({p, chan})
         {3'd0, 3'd0}: v = 8'd255; {3'd0, 3'd1}: v = 8'd148; {3'd0, 3'd2}: v = 8'd40;
         {3'd0, 3'd3}: v = 8'd12;  {3'd0, 3'd4}: v = 8'd8;   {3'd0, 3'd5}: v = 8'd24;
         {3'd1, 3'd0}: v = 8'd150; {3'd1, 3'd1}: v = 8'd190; {3'd1, 3'd2}: v = 8'd255;
         {3'd1, 3'd3}: v = 8'd8;   {3'd1, 3'd4}: v = 8'd10;  {3'd1, 3'd5}: v = 8'd28;
         {3'd2, 3'd0}: v = 8'd150; {3'd2, 3'd1}: v = 8'd255; {3'd2, 3'd2}: v = 8'd60;
         {3'd2, 3'd3}: v = 8'd10;  {3'd2, 3'd4}: v = 8'd20;  {3'd2, 3'd5}: v = 8'd10;
         {3'd3, 3'd0}: v = 8'd255; {3'd3, 3'd1}: v = 8'd70;  {3'd3, 3'd2}: v = 8'd190;
         {3'd3, 3'd3}: v = 8'd24;  {3'd3, 3'd4}: v = 8'd6;   {3'd3, 3'd5}: v = 8'd26;
         {3'd4, 3'd0}: v = 8'd255; {3'd4, 3'd1}: v = 8'd220; {3'd4, 3'd2}: v = 8'd60;
         {3'd4, 3'd3}: v = 8'd26;  {3'd4, 3'd4}: v = 8'd18;  {3'd4, 3'd5}: v = 8'd4;
         default: v = 8'd0;
      endcase
      return v;
   endfunction

   // exp(-18 x^2) at x = k/32, Q15
   function automatic logic [15:0] gauss_tab(input logic [4:0] k);
      logic [15:0] v;
      case (k)
         5'd0:  v = 16'd32768; 5'd1:  v = 16'd32197; 5'd2:  v = 16'd30543;
         5'd3:  v = 16'd27973; 5'd4:  v = 16'd24735; 5'd5:  v = 16'd21115;
         5'd6:  v = 16'd17403; 5'd7:  v = 16'd13848; 5'd8:  v = 16'd10638;
         5'd9:  v = 16'd7890;  5'd10: v = 16'd5650;  5'd11: v = 16'd3906;
         5'd12: v = 16'd2607;  5'd13: v = 16'd1680;  5'd14: v = 16'd1045;
         5'd15: v = 16'd628;   5'd16: v = 16'd364;   5'd17: v = 16'd204;
         5'd18: v = 16'd110;   5'd19: v = 16'd57;    5'd20: v = 16'd29;
         5'd21: v = 16'd14;    5'd22: v = 16'd7;     5'd23: v = 16'd3;
         5'd24: v = 16'd1;     5'd25: v = 16'd1;
         default: v = 16'd0;
      endcase
      return v;
   endfunction

   function automatic logic [7:0] scale_chan(input logic [7:0] ch, input logic [15:0] lum);
      logic [24:0] p;
      logic [9:0]  v;
      p = 25'(ch) * 25'(lum) + 25'd16384;
      v = p[24:15];
      return (v > 10'd255) ? 8'd255 : v[7:0];
   endfunction

endpackage

### rtl/cbls_ctrl.sv
// Sequencer of the copper bar line shader: steps the datapath through each item.
module cbls_ctrl #(
   parameter int NUM_BARS = 6
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_kind,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output cbls_pkg::cmd_type    cmd,
   output logic [((NUM_BARS < cbls_pkg::TABLE_BARS ? NUM_BARS : cbls_pkg::TABLE_BARS) > 1
                  ? $clog2(NUM_BARS < cbls_pkg::TABLE_BARS ? NUM_BARS
                                                           : cbls_pkg::TABLE_BARS)
                  : 1) - 1:0] bar_idx,
   input  cbls_pkg::status_type status
);

   localparam int ACTIVE = (NUM_BARS < cbls_pkg::TABLE_BARS) ? NUM_BARS
                                                              : cbls_pkg::TABLE_BARS;
   localparam int BAR_W  = (ACTIVE > 1) ? $clog2(ACTIVE) : 1;

   typedef enum logic [4:0] {
      S_IDLE, S_ANGLE, S_SINU, S_Q1, S_Q2, S_Q3, S_Q4, S_POS, S_ROW,
      S_LCHK, S_HALF1, S_HALF2, S_DIFF, S_DTEST, S_DIV, S_LUMU,
      S_BODY, S_GAUSS, S_LUM, S_RGB, S_FINISH
   } state_type;

   state_type        state_ff, state_in;
   logic [BAR_W-1:0] bar_ff, bar_in;
   logic [3:0]       step_ff, step_in;
   logic             line_ff, line_in;
   logic             valid_ff, valid_in;
   logic             last_bar;

   assign last_bar  = (bar_ff == BAR_W'(ACTIVE - 1));
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = valid_ff;
   assign bar_idx   = bar_ff;

   always_comb begin
      state_in = state_ff;
      bar_in   = bar_ff;
      step_in  = step_ff;
      line_in  = line_ff;
      valid_in = valid_ff & ~rsp_ready;
      cmd.op   = cbls_pkg::OP_NOP;
      cmd.div_step = step_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.op   = cbls_pkg::OP_LOAD;
               bar_in   = '0;
               line_in  = (req_kind == cbls_pkg::KIND_LINE);
               state_in = (req_kind == cbls_pkg::KIND_LINE) ? S_LCHK : S_ANGLE;
            end
         end
         S_ANGLE: begin cmd.op = cbls_pkg::OP_ANGLE; state_in = S_SINU; end
         S_SINU:  begin cmd.op = cbls_pkg::OP_SINU;  state_in = S_Q1; end
         S_Q1:    begin cmd.op = cbls_pkg::OP_Q1;    state_in = S_Q2; end
         S_Q2:    begin cmd.op = cbls_pkg::OP_Q2;    state_in = S_Q3; end
         S_Q3:    begin cmd.op = cbls_pkg::OP_Q3;    state_in = S_Q4; end
         S_Q4: begin
            cmd.op   = cbls_pkg::OP_Q4;
            state_in = line_ff ? S_BODY : S_POS;
         end
         S_POS:   begin cmd.op = cbls_pkg::OP_POS;   state_in = S_ROW; end
         S_ROW: begin
            cmd.op = cbls_pkg::OP_ROW;
            if (last_bar) begin
               state_in = S_IDLE;
            end else begin
               bar_in   = bar_ff + 1'b1;
               state_in = S_ANGLE;
            end
         end
         S_LCHK:  state_in = status.line_ok ? S_HALF1 : S_FINISH;
         S_HALF1: begin cmd.op = cbls_pkg::OP_HALF1; state_in = S_HALF2; end
         S_HALF2: begin cmd.op = cbls_pkg::OP_HALF2; state_in = S_DIFF; end
         S_DIFF:  begin cmd.op = cbls_pkg::OP_DIFF;  state_in = S_DTEST; end
         S_DTEST: begin
            cmd.op  = cbls_pkg::OP_DIVINIT;
            step_in = 4'(cbls_pkg::DIV_BITS - 1);
            if (status.covered) begin
               state_in = S_DIV;
            end else if (last_bar) begin
               state_in = S_FINISH;
            end else begin
               bar_in   = bar_ff + 1'b1;
               state_in = S_HALF1;
            end
         end
         S_DIV: begin
            cmd.op = cbls_pkg::OP_DIV;
            if (step_ff == 4'd0) begin
               state_in = S_LUMU;
            end else begin
               step_in = step_ff - 4'd1;
            end
         end
         S_LUMU:  begin cmd.op = cbls_pkg::OP_LUMU;  state_in = S_Q1; end
         S_BODY:  begin cmd.op = cbls_pkg::OP_BODY;  state_in = S_GAUSS; end
         S_GAUSS: begin cmd.op = cbls_pkg::OP_GAUSS; state_in = S_LUM; end
         S_LUM:   begin cmd.op = cbls_pkg::OP_LUM;   state_in = S_RGB; end
         S_RGB: begin
            cmd.op = cbls_pkg::OP_RGB;
            if (last_bar) begin
               state_in = S_FINISH;
            end else begin
               bar_in   = bar_ff + 1'b1;
               state_in = S_HALF1;
            end
         end
         S_FINISH: begin
            if (!valid_ff || rsp_ready) begin
               cmd.op   = cbls_pkg::OP_EMIT;
               valid_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         bar_ff   <= '0;
         step_ff  <= 4'd0;
         line_ff  <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         bar_ff   <= bar_in;
         step_ff  <= step_in;
         line_ff  <= line_in;
         valid_ff <= valid_in;
      end
   end

endmodule

### rtl/cbls_dp.sv
// Datapath of the copper bar line shader: centre store, shared arithmetic, result register.
module cbls_dp #(
   parameter int NUM_BARS = 6
) (
   input  logic                 clock,
   input  logic                 reset,
   input  cbls_pkg::cmd_type    cmd,
   input  logic [((NUM_BARS < cbls_pkg::TABLE_BARS ? NUM_BARS : cbls_pkg::TABLE_BARS) > 1
                  ? $clog2(NUM_BARS < cbls_pkg::TABLE_BARS ? NUM_BARS
                                                           : cbls_pkg::TABLE_BARS)
                  : 1) - 1:0] bar_idx,
   output cbls_pkg::status_type status,
   input  logic                 in_kind,
   input  logic [31:0]          in_time,
   input  logic [9:0]           in_line,
   input  logic [2:0]           palette_sel,
   input  logic [10:0]          line_count,
   output logic [9:0]           line_number,
   output logic [7:0]           red,
   output logic [7:0]           green,
   output logic [7:0]           blue
);

   localparam int ACTIVE = (NUM_BARS < cbls_pkg::TABLE_BARS) ? NUM_BARS
                                                              : cbls_pkg::TABLE_BARS;

   logic [cbls_pkg::CENTRE_W-1:0] centre_ff [ACTIVE];
   logic        frame_seen_ff;
   logic [31:0] time_ff;
   logic [9:0]  y_ff;
   logic [31:0] ang_ff;
   logic        neg_ff;
   logic [15:0] u_ff, u2_ff, t_ff, s_ff;
   logic [31:0] pos_ff;
   logic [25:0] hn_ff;
   logic [15:0] half_ff;
   logic        dneg_ff;
   logic [21:0] adiff_ff;
   logic        covered_ff;
   logic [24:0] num_ff;
   logic [8:0]  quot_ff;
   logic [8:0]  e_ff;
   logic [15:0] body_ff, g_ff, lum_ff;
   logic [7:0]  r_ff, g_col_ff, b_ff;
   logic [9:0]  line_out_ff;
   logic [7:0]  r_out_ff, g_out_ff, b_out_ff;

   logic [2:0]                    tb;
   logic [cbls_pkg::ROWS_W-1:0]   rows;
   logic [63:0]                   ang_prod;
   logic [31:0]                   ang_next;
   logic [15:0]                   u_sin;
   logic [31:0]                   uu_prod;
   logic [27:0]                   q2_prod;
   logic [31:0]                   q3_prod;
   logic [31:0]                   q4_prod;
   logic [30:0]                   pos_base;
   logic [29:0]                   amp_prod;
   logic [31:0]                   pos_next;
   logic [42:0]                   row_prod;
   logic [15:0]                   hgt_rows;
   logic [20:0]                   half_num;
   logic [41:0]                   half_prod;
   logic signed [22:0]            diff;
   logic [21:0]                   adiff;
   logic [24:0]                   div_cand;
   logic signed [9:0]             dval;
   logic signed [10:0]            hval;
   logic [31:0]                   body_prod;
   logic [5:0]                    gk;
   logic [15:0]                   g0, g1;
   logic [18:0]                   g_prod;
   logic [15:0]                   g_next;
   logic [29:0]                   lum_prod;
   logic [16:0]                   lum_sum;

   assign tb = 3'(bar_idx);

   always_comb begin
      if (line_count == 11'd0) begin
         rows = 11'd1;
      end else if (line_count > 11'(cbls_pkg::MAX_LINES)) begin
         rows = 11'(cbls_pkg::MAX_LINES);
      end else begin
         rows = line_count;
      end
   end

   assign status.line_ok = frame_seen_ff && ({1'b0, y_ff} < rows);
   assign status.covered = covered_ff;

   // frame work: angle, sine, centre row
   assign ang_prod = 64'(time_ff) * 64'(cbls_pkg::bar_speed(tb));
   assign ang_next = ang_prod[47:16] + cbls_pkg::bar_phase(tb);
   assign u_sin    = ang_ff[30] ? 16'(17'd32768 - 17'(ang_ff[29:15])) : 16'(ang_ff[29:15]);

   // quarter-wave polynomial, shared by frame and line work
   assign uu_prod = 32'(u_ff) * 32'(u_ff);
   assign q2_prod = 28'd2320 * 28'(u2_ff);
   assign q3_prod = 32'(t_ff) * 32'(u2_ff);
   assign q4_prod = 32'(t_ff) * 32'(u_ff);

   assign pos_base = {cbls_pkg::bar_centre_q16(tb), 15'd0};
   assign amp_prod = 30'(cbls_pkg::bar_amp_q16(tb)) * 30'(s_ff);
   always_comb begin
      if (!neg_ff) begin
         pos_next = 32'(pos_base) + 32'(amp_prod);
      end else if (31'(amp_prod) > pos_base) begin
         pos_next = 32'd0;
      end else begin
         pos_next = 32'(pos_base - 31'(amp_prod));
      end
   end
   assign row_prod = 43'(pos_ff) * 43'(rows) + 43'd1048576;

   // line work: half height, distance, Q8 offset
   assign hgt_rows  = 16'(cbls_pkg::bar_height(tb)) * 16'(rows);
   assign half_num  = 21'(hn_ff >> cbls_pkg::HALF_SHIFT);
   assign half_prod = 42'(half_num) * 42'(cbls_pkg::HALF_RECIP);
   assign diff      = $signed({3'd0, y_ff, 10'd0}) - $signed({1'b0, centre_ff[bar_idx]});
   assign adiff     = diff[22] ? 22'(-diff) : 22'(diff);
   assign div_cand  = 25'(half_ff) << cmd.div_step;
   assign dval      = dneg_ff ? -$signed({1'b0, quot_ff}) : $signed({1'b0, quot_ff});
   assign hval      = 11'(dval) + 11'sd90;

   // luminance
   assign body_prod = 32'(s_ff) * 32'(s_ff);
   assign gk        = 6'(e_ff >> 3);
   assign g0        = cbls_pkg::gauss_tab(gk[4:0]);
   assign g1        = cbls_pkg::gauss_tab(gk[4:0] + 5'd1);
   assign g_prod    = 19'(g0 - g1) * 19'(e_ff[2:0]) + 19'd4;
   assign g_next    = (gk >= 6'(cbls_pkg::GAUSS_LAST)) ? 16'd0 : 16'(g0 - g_prod[18:3]);
   assign lum_prod  = 30'(body_ff) * 30'd25559 + 30'd16384;
   assign lum_sum   = 17'(lum_prod[29:15]) + 17'((17'(g_ff) + 17'd1) >> 1);

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_seen_ff <= 1'b0;
      end else if (cmd.op == cbls_pkg::OP_LOAD && in_kind == cbls_pkg::KIND_FRAME) begin
         frame_seen_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      case (cmd.op)
         cbls_pkg::OP_LOAD: begin
            time_ff  <= in_time;
            y_ff     <= in_line;
            r_ff     <= cbls_pkg::pal_value(palette_sel, 3'd3);
            g_col_ff <= cbls_pkg::pal_value(palette_sel, 3'd4);
            b_ff     <= cbls_pkg::pal_value(palette_sel, 3'd5);
         end
         cbls_pkg::OP_ANGLE: ang_ff <= ang_next;
         cbls_pkg::OP_SINU: begin
            u_ff   <= u_sin;
            neg_ff <= ang_ff[31];
         end
         cbls_pkg::OP_Q1: u2_ff <= uu_prod[30:15];
         cbls_pkg::OP_Q2: t_ff  <= 16'd21024 - 16'(q2_prod[27:15]);
         cbls_pkg::OP_Q3: t_ff  <= 16'd51472 - q3_prod[30:15];
         cbls_pkg::OP_Q4: s_ff  <= q4_prod[30:15];
         cbls_pkg::OP_POS: pos_ff <= pos_next;
         cbls_pkg::OP_ROW: centre_ff[bar_idx] <= row_prod[42:21];
         cbls_pkg::OP_HALF1: hn_ff <= {hgt_rows, 10'd0} + 26'(cbls_pkg::REF_LINES);
         cbls_pkg::OP_HALF2: half_ff <= half_prod[39:24];
         cbls_pkg::OP_DIFF: begin
            dneg_ff    <= diff[22];
            adiff_ff   <= adiff;
            covered_ff <= (half_ff >= 16'd512) && (adiff <= 22'(half_ff));
         end
         cbls_pkg::OP_DIVINIT: begin
            num_ff  <= {1'b0, adiff_ff[15:0], 8'd0} + 25'(half_ff >> 1);
            quot_ff <= 9'd0;
         end
         cbls_pkg::OP_DIV: begin
            if (num_ff >= div_cand) begin
               num_ff                <= num_ff - div_cand;
               quot_ff[cmd.div_step] <= 1'b1;
            end
         end
         cbls_pkg::OP_LUMU: begin
            u_ff <= {9'(9'd256 - quot_ff), 7'd0};
            e_ff <= hval[10] ? 9'(-hval) : 9'(hval);
         end
         cbls_pkg::OP_BODY: body_ff <= body_prod[30:15];
         cbls_pkg::OP_GAUSS: g_ff <= g_next;
         cbls_pkg::OP_LUM: lum_ff <= (lum_sum > 17'd32768) ? 16'd32768 : lum_sum[15:0];
         cbls_pkg::OP_RGB: begin
            r_ff     <= cbls_pkg::scale_chan(cbls_pkg::pal_value(palette_sel, 3'd0), lum_ff);
            g_col_ff <= cbls_pkg::scale_chan(cbls_pkg::pal_value(palette_sel, 3'd1), lum_ff);
            b_ff     <= cbls_pkg::scale_chan(cbls_pkg::pal_value(palette_sel, 3'd2), lum_ff);
         end
         cbls_pkg::OP_EMIT: begin
            line_out_ff <= y_ff;
            r_out_ff    <= r_ff;
            g_out_ff    <= g_col_ff;
            b_out_ff    <= b_ff;
         end
         default: ;
      endcase
   end

   assign line_number = line_out_ff;
   assign red         = r_out_ff;
   assign green       = g_out_ff;
   assign blue        = b_out_ff;

endmodule

### rtl/copper_bar_line_shader.sv
// Top level of the copper bar line shader: stream ports, control registers, sequencer, datapath.
// Frame item: angle, sine, quarter wave, position and centre row per bar; no result item.
// Line item: half height, distance and cover test per bar (six bars at most); a covering bar
//   adds division, quarter wave and shading. Off the field or before a frame no bar is visited.
// One item at a time; the next item is taken while a finished result waits in the output register.
// Synchronous active-high reset: idle sequencer, no result pending, no frame seen,
//   palette 0 and 240 lines.
module copper_bar_line_shader #(
   parameter int NUM_BARS = 6
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,  // time_ticks[31:0], line_index[41:32], zero pad
   input  logic        req_tuser,  // kind: 0 frame, 1 line
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,  // line_number[9:0], red[17:10], green[25:18], blue[33:26]
   input  logic        csr_wen,
   input  logic        csr_index,
   input  logic [10:0] csr_wdata
);

   localparam int ACTIVE = (NUM_BARS < cbls_pkg::TABLE_BARS) ? NUM_BARS
                                                              : cbls_pkg::TABLE_BARS;
   localparam int BAR_W  = (ACTIVE > 1) ? $clog2(ACTIVE) : 1;

   logic [2:0]           palette_ff;
   logic [10:0]          lines_ff;
   cbls_pkg::cmd_type    cmd;
   cbls_pkg::status_type status;
   logic [BAR_W-1:0]     bar_idx;
   logic [9:0]           line_number;
   logic [7:0]           red, green, blue;

   // control registers; to be written only while idle, which the block itself does not enforce
   always_ff @(posedge clock) begin
      if (reset) begin
         palette_ff <= 3'd0;
         lines_ff   <= 11'd240;
      end else if (csr_wen) begin
         case (csr_index)
            cbls_pkg::CSR_PALETTE: palette_ff <= csr_wdata[2:0];
            cbls_pkg::CSR_LINES:   lines_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // sequencer: walks bars and arithmetic steps, owns the handshakes
   cbls_ctrl #(.NUM_BARS(NUM_BARS)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_kind  (req_tuser),
      .req_ready (req_tready),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .cmd       (cmd),
      .bar_idx   (bar_idx),
      .status    (status)
   );

   // datapath: holds bar centres and does one step per command
   cbls_dp #(.NUM_BARS(NUM_BARS)) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .bar_idx     (bar_idx),
      .status      (status),
      .in_kind     (req_tuser),
      .in_time     (req_tdata[31:0]),
      .in_line     (req_tdata[41:32]),
      .palette_sel (palette_ff),
      .line_count  (lines_ff),
      .line_number (line_number),
      .red         (red),
      .green       (green),
      .blue        (blue)
   );

   assign rsp_tdata = {6'd0, blue, green, red, line_number};

`ifndef ASSERT_OFF
   // busy right after taking an item
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("item accepted but block not busy next cycle");

   // no result rises right after a frame item is taken
   a_frame_no_result: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser == cbls_pkg::KIND_FRAME |=> !$rose(rsp_tvalid))
      else $error("result appeared right after a frame item");

   // a result only follows a busy cycle
   a_result_after_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(!req_tready))
      else $error("result raised while idle");
`endif

endmodule

### test/tb.sv
// Self-checking testbench of the copper bar line shader: directed and random items.
`timescale 1ns / 1ps

module tb;

   localparam int LIMIT_CYCLES  = 2000000;
   localparam int SETTLE_CYCLES = 200;   // longer than the slowest line item
   localparam int RANDOM_ITEMS  = 1150;

   typedef struct {
      logic [9:0] line_number;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } colour_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [47:0] req_tdata;
   logic        req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [39:0] rsp_tdata;
   logic        csr_wen;
   logic        csr_index;
   logic [10:0] csr_wdata;

   copper_bar_line_shader i_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_wen(csr_wen), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // bar table: centre and amplitude in Q16 of the field, speed and phase in turns
   int unsigned centre_frac [6] = '{10486, 20316, 29491, 38011, 47186, 56361};
   int unsigned amp_frac    [6] = '{8520, 10486, 9175, 11141, 9830, 7864};
   int unsigned speed_turns [6] = '{567359179, 868127900, 416974818,
                                    1045854872, 663058317, 1223581843};
   int unsigned phase_turns [6] = '{0, 1298774024, 2324121937,
                                    478495693, 3281113323, 1777269717};
   int unsigned height_rows [6] = '{22, 18, 26, 16, 24, 20};
   // bar r, g, b then background r, g, b
   int unsigned palettes [5][6] = '{
      '{255, 148, 40, 12, 8, 24},
      '{150, 190, 255, 8, 10, 28},
      '{150, 255, 60, 10, 20, 10},
      '{255, 70, 190, 24, 6, 26},
      '{255, 220, 60, 26, 18, 4}};
   int unsigned gauss_q15 [27] = '{32768, 32197, 30543, 27973, 24735, 21115, 17403, 13848,
      10638, 7890, 5650, 3906, 2607, 1680, 1045, 628, 364, 204, 110, 57, 29, 14, 7, 3,
      1, 1, 0};

   // shadow state of the shader
   logic [2:0]  sh_palette;
   logic [10:0] sh_lines;
   logic [21:0] sh_centre [6];
   bit          sh_frame_seen;

   colour_type  pending_colours [$];
   int unsigned cycles;
   int unsigned mismatches;
   int unsigned colours_checked;
   int unsigned lines_sent, frames_sent, covered_lines;
   bit          no_idle;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT_CYCLES) begin
         $display("timeout after %0d cycles, %0d colours outstanding",
                  cycles, pending_colours.size());
         $display("** copper_bar_line_shader: FAILED **");
         $finish;
      end
   end

   function automatic int unsigned field_rows();
      if (sh_lines == 0) return 1;
      if (sh_lines > 1024) return 1024;
      return 32'(sh_lines);
   endfunction

   function automatic int unsigned quarter_wave(int unsigned u);
      int unsigned u2, t;
      u2 = (u * u) >> 15;
      t = (2320 * u2) >> 15;
      t = 21024 - t;
      t = (t * u2) >> 15;
      t = 51472 - t;
      return (t * u) >> 15;
   endfunction

   function automatic int signed wave_q15(logic [31:0] angle);
      int unsigned f, u;
      int signed s;
      f = 32'(angle[29:15]);
      u = angle[30] ? 32768 - f : f;
      s = quarter_wave(u);
      return angle[31] ? -s : s;
   endfunction

   function automatic int unsigned highlight(int unsigned e);
      int unsigned k, f, g0, g1;
      k = e >> 3;
      f = e & 7;
      if (k >= 26) return 0;
      g0 = gauss_q15[k];
      g1 = gauss_q15[k + 1];
      return g0 - (((g0 - g1) * f + 4) >> 3);
   endfunction

   function automatic int unsigned bar_luma(int signed d);
      int unsigned ad, s, body, g, v;
      int signed h;
      ad = (d < 0) ? -d : d;
      if (ad > 256) ad = 256;
      h = d + 90;
      s = quarter_wave((256 - ad) << 7);
      body = (s * s) >> 15;
      g = highlight((h < 0) ? -h : h);
      v = ((body * 25559 + 16384) >> 15) + ((g + 1) >> 1);
      return (v > 32768) ? 32768 : v;
   endfunction

   function automatic logic [7:0] shade(int unsigned ch, int unsigned lum);
      int unsigned v;
      v = (ch * lum + 16384) >> 15;
      return (v > 255) ? 8'd255 : v[7:0];
   endfunction

   // Latch the bar centres for a new frame time.
   function automatic void place_bars(logic [31:0] t);
      logic [63:0] prod;
      logic [31:0] angle;
      longint signed pos;
      longint unsigned rows;
      rows = field_rows();
      for (int b = 0; b < 6; b++) begin
         prod = 64'(t) * 64'(speed_turns[b]);
         angle = prod[47:16] + phase_turns[b];
         pos = longint'(centre_frac[b]) * 32768 + longint'(amp_frac[b]) * wave_q15(angle);
         if (pos < 0) pos = 0;
         sh_centre[b] = 22'((longint'(pos) * rows + (1 << 20)) >> 21);
      end
      sh_frame_seen = 1'b1;
   endfunction

   function automatic colour_type line_colour(logic [9:0] y);
      colour_type c;
      int unsigned p, rows, half, adiff, dm, lum;
      int signed diff, d;
      p = sh_palette % 5;
      rows = field_rows();
      c.line_number = y;
      c.red = 8'(palettes[p][3]);
      c.green = 8'(palettes[p][4]);
      c.blue = 8'(palettes[p][5]);
      if (sh_frame_seen && y < rows) begin
         for (int b = 0; b < 6; b++) begin
            half = (height_rows[b] * rows * 1024 + 240) / 480;
            if (half < 512) continue;
            diff = int'(y) * 1024 - int'(sh_centre[b]);
            adiff = (diff < 0) ? -diff : diff;
            if (adiff > half) continue;
            dm = (adiff * 256 + half / 2) / half;
            d = (diff < 0) ? -int'(dm) : int'(dm);
            lum = bar_luma(d);
            c.red = shade(palettes[p][0], lum);
            c.green = shade(palettes[p][1], lum);
            c.blue = shade(palettes[p][2], lum);
         end
      end
      return c;
   endfunction

   // Result side: stall a random number of cycles per item, then accept.
   initial begin
      int stall;
      rsp_tready = 1'b0;
      @(negedge reset);
      forever begin
         stall = no_idle ? 0 : $urandom_range(0, 15);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   // Compare each accepted colour with the oldest expectation.
   always @(posedge clock) begin
      colour_type want, got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.line_number = rsp_tdata[9:0];
         got.red = rsp_tdata[17:10];
         got.green = rsp_tdata[25:18];
         got.blue = rsp_tdata[33:26];
         if (pending_colours.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected colour: line %0d rgb %0d %0d %0d",
                        got.line_number, got.red, got.green, got.blue);
         end else begin
            want = pending_colours.pop_front();
            colours_checked++;
            if (got.line_number !== want.line_number || got.red !== want.red ||
                got.green !== want.green || got.blue !== want.blue) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: want line %0d rgb %0d %0d %0d, got line %0d rgb %0d %0d %0d",
                           want.line_number, want.red, want.green, want.blue,
                           got.line_number, got.red, got.green, got.blue);
            end
         end
      end
   end

   // Send one item after a random gap; valid stays high until the next gap.
   task automatic send_item(logic kind, logic [31:0] t, logic [9:0] y);
      int gap;
      colour_type c;
      gap = no_idle ? 0 : $urandom_range(0, 15);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= kind;
      req_tdata <= {6'd0, y, t};
      do @(posedge clock); while (!req_tready);
      if (kind == cbls_pkg::KIND_FRAME) begin
         place_bars(t);
         frames_sent++;
      end else begin
         c = line_colour(y);
         if (sh_frame_seen && y < field_rows() &&
             (c.red != palettes[sh_palette % 5][3] || c.green != palettes[sh_palette % 5][4]))
            covered_lines++;
         pending_colours.push_back(c);
         lines_sent++;
      end
   endtask

   // Drop valid, hold until every colour is back, then let a frame item finish.
   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending_colours.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic idx, logic [10:0] value);
      drain();
      csr_wen <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_wen <= 1'b0;
      if (idx == cbls_pkg::CSR_PALETTE) sh_palette = value[2:0];
      else sh_lines = value;
   endtask

   // Lines before any frame and both ends of the line range.
   task automatic test_before_frame();
      send_item(cbls_pkg::KIND_LINE, 32'hFFFF_FFFF, 10'd0);
      send_item(cbls_pkg::KIND_LINE, 32'd0, 10'd1023);
      send_item(cbls_pkg::KIND_LINE, 32'd0, 10'd100);
   endtask

   // Time extremes, each bar's centre line, and lines beyond the field.
   task automatic test_frames_and_bars();
      send_item(cbls_pkg::KIND_FRAME, 32'd0, 10'h3FF);
      for (int b = 0; b < 6; b++)
         send_item(cbls_pkg::KIND_LINE, 32'd0, sh_centre[b][19:10]);
      send_item(cbls_pkg::KIND_FRAME, 32'hFFFF_FFFF, 10'd0);
      for (int b = 0; b < 6; b++)
         send_item(cbls_pkg::KIND_LINE, 32'd0, sh_centre[b][19:10] + 10'd1);
      send_item(cbls_pkg::KIND_LINE, 32'd0, 10'd239);
      send_item(cbls_pkg::KIND_LINE, 32'd0, 10'd240);
      send_item(cbls_pkg::KIND_LINE, 32'd0, 10'd1023);
   endtask

   // Every palette, out-of-range ones too, on a covered line.
   task automatic test_palettes();
      for (int p = 0; p < 8; p++) begin
         write_reg(cbls_pkg::CSR_PALETTE, 11'(p));
         send_item(cbls_pkg::KIND_LINE, 32'd0, sh_centre[2][19:10]);
      end
   endtask

   // Zero, tiny, full and oversized field heights; centres latch the count at frame time.
   task automatic test_line_counts();
      logic [10:0] counts [5] = '{11'd0, 11'd1, 11'd1024, 11'd1025, 11'd2047};
      foreach (counts[i]) begin
         write_reg(cbls_pkg::CSR_LINES, counts[i]);
         send_item(cbls_pkg::KIND_FRAME, $urandom, 10'd0);
         send_item(cbls_pkg::KIND_LINE, 32'd0, 10'd0);
         send_item(cbls_pkg::KIND_LINE, 32'd0, sh_centre[4][19:10]);
         send_item(cbls_pkg::KIND_LINE, 32'd0, 10'd1023);
      end
      write_reg(cbls_pkg::CSR_LINES, 11'd480);   // change after the frame: heights use the new count
      send_item(cbls_pkg::KIND_LINE, 32'd0, sh_centre[0][19:10]);
   endtask

   // Frames followed by runs of lines, mostly inside the field, across several settings.
   task automatic test_random();
      logic [10:0] counts [9] = '{11'd240, 11'd1024, 11'd16, 11'd2047, 11'd480,
                                  11'd1, 11'd0, 11'd600, 11'd1025};
      int sent;
      int rows;
      logic [9:0] y;
      sent = 0;
      for (int phase = 0; phase < 9; phase++) begin
         write_reg(cbls_pkg::CSR_PALETTE, 11'($urandom_range(0, 7)));
         write_reg(cbls_pkg::CSR_LINES,
                   (phase == 8) ? 11'($urandom_range(1, 2047)) : counts[phase]);
         no_idle = (phase % 3 == 1);
         rows = field_rows();
         for (int i = 0; i < RANDOM_ITEMS / 9; i++) begin
            if ($urandom_range(0, 15) == 0) begin
               send_item(cbls_pkg::KIND_FRAME, $urandom, 10'($urandom));
            end else begin
               if ($urandom_range(0, 9) == 0) y = 10'($urandom);
               else y = 10'($urandom_range(0, rows - 1));
               send_item(cbls_pkg::KIND_LINE, $urandom, y);
            end
            sent++;
         end
      end
      no_idle = 1'b0;
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tuser = cbls_pkg::KIND_FRAME;
      req_tdata = '0;
      csr_wen = 1'b0;
      csr_index = cbls_pkg::CSR_PALETTE;
      csr_wdata = '0;
      cycles = 0;
      mismatches = 0;
      colours_checked = 0;
      lines_sent = 0;
      frames_sent = 0;
      covered_lines = 0;
      no_idle = 1'b0;
      sh_palette = 3'd0;
      sh_lines = 11'd240;
      sh_frame_seen = 1'b0;
      foreach (sh_centre[i]) sh_centre[i] = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_before_frame();
      test_frames_and_bars();
      test_palettes();
      test_line_counts();
      test_random();
      drain();

      $display("covered %0d frames and %0d lines (%0d lit by a bar), %0d colours checked",
               frames_sent, lines_sent, covered_lines, colours_checked);
      $display("all palettes 0..7 and line counts 0..2047 extremes, %0d mismatches", mismatches);
      if (mismatches == 0 && pending_colours.size() == 0) begin
         $display("** copper_bar_line_shader: PASSED **");
      end else begin
         $display("** copper_bar_line_shader: FAILED **");
      end
      $finish;
   end

endmodule

### copper_bar_line_shader.f
rtl/cbls_pkg.sv
rtl/cbls_ctrl.sv
rtl/cbls_dp.sv
rtl/copper_bar_line_shader.sv
test/tb.sv
